// ===== rtl/sfla_pkg.sv =====
// Shared types, codes and constants of the struct field layout allocator.
package sfla_pkg;

  localparam int unsigned MaxHolesDefault = 16;
  localparam int unsigned PosW            = 19;
  localparam int unsigned SizeW           = 16;
  localparam int unsigned AddrW           = 3;
  localparam int unsigned DataW           = 32;
  localparam logic [3:0]  PwbReset        = 4'd4;
  localparam logic [AddrW-3:0] RegPwbIdx  = '0;

  typedef enum logic [1:0] {
    CMD_SCALAR  = 2'd0,
    CMD_POINTER = 2'd1,
    CMD_END     = 2'd2
  } sfla_cmd_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_BIT    = 2'd1,
    KIND_SLOT   = 2'd2,
    KIND_TOTALS = 2'd3
  } sfla_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_EMIT
  } sfla_state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] field_bytes;
  } sfla_in_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [PosW-1:0]  position;
    logic [SizeW-1:0] scalar_area_bytes;
    logic [SizeW-1:0] pointer_slot_count;
    logic             overflow;
  } sfla_out_t;

endpackage

// ===== rtl/struct_field_layout_allocator_top.sv =====
// Struct field layout allocator: sequencer, hole table and shared align/fit unit.
//
// Lays out one record's fields, one input beat per field, and returns one result
// beat per valid item. A scalar of 1, 2, 4 or 8 bytes gets a naturally aligned
// byte offset: the hole table is scanned first fit, one entry per cycle through
// a single align/fit unit, and the chosen hole is trimmed, split or removed.
// When no hole fits, the field is appended at the aligned end of the scalar area
// and the alignment gap becomes a new hole. Booleans fill the current partial
// byte, then a one-byte hole, then a new tail byte. Pointer fields take
// consecutive slot indices, and an end-of-record beat reports the totals and
// clears the layout. Command 3 and bad scalar sizes are taken and dropped.
// A pointer, end-of-record or mid-byte boolean item goes straight to its emit
// step. A scalar or byte-opening boolean scans the hole table when it holds
// holes, goes to the tail when the scan misses, and moves entries when a
// used-up hole is removed or a split inserts a hole, before its emit step.
// The hole table has one read port, so the scan and every entry move go one
// entry at a time. The input side stalls for the whole of an item; a finished
// result waits in the output register, so the next item is taken while it
// waits, and that item's emit step holds while the register is still full.
// Register 0 (byte address 0) holds the pointer word size used to round the
// scalar area at end of record when pointer slots were used.
module struct_field_layout_allocator_top #(
  parameter int unsigned MaxHoles = sfla_pkg::MaxHolesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sfla_pkg::sfla_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sfla_pkg::sfla_out_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfla_pkg::AddrW-1:0]    paddr,
  input  logic [sfla_pkg::DataW-1:0]    pwdata,
  output logic [sfla_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import sfla_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxHoles);
  localparam int unsigned CntW = $clog2(MaxHoles + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxHoles);

  // Control state
  sfla_state_e      state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PosW-1:0]  bit_cur_q, bit_cur_d;
  logic [15:0]      send_q, send_d;
  logic [15:0]      slot_q, slot_d;
  logic             ovf_q, ovf_d;
  logic [3:0]       pwb_q, pwb_d;
  logic             out_valid_q, out_valid_d;

  // Per-item working registers
  logic [3:0]       size_q, size_d;
  logic             is_bool_q, is_bool_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  ins_at_q, ins_at_d;
  logic [31:0]      ins_word_q, ins_word_d;
  logic [1:0]       res_kind_q, res_kind_d;
  logic [PosW-1:0]  res_pos_q, res_pos_d;
  logic [15:0]      res_area_q, res_area_d;
  logic [15:0]      res_slots_q, res_slots_d;
  sfla_out_t        out_q, out_d;

  // Hole table: {offset, length} per entry
  logic [31:0]      hole_mem [MaxHoles];
  logic [31:0]      rdata_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_wa;
  logic [31:0]      mem_wd;
  logic [IdxW-1:0]  rd_addr;

  // Handshake and decode
  logic in_acc, out_free, size_ok, mid_byte;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign size_ok    = in_data_i.field_bytes inside {4'd1, 4'd2, 4'd4, 4'd8};
  assign mid_byte   = (bit_cur_q[2:0] != 3'd0);

  // Shared align/fit unit: operand is the scanned hole or the scalar tail
  logic [15:0] h_off, h_len, u_off, u_remain;
  logic [2:0]  szm1, u_pad;
  logic [16:0] u_al, u_end;
  logic        u_fit, pad_nz, remain_nz, len_gt;
  logic [PosW-1:0] bpos;
  assign h_off     = rdata_q[31:16];
  assign h_len     = rdata_q[15:0];
  assign u_off     = (state_q == ST_APPEND) ? send_q : h_off;
  assign szm1      = 3'(size_q - 4'd1);
  assign u_al      = ({1'b0, u_off} + {14'd0, szm1}) & ~{14'd0, szm1};
  assign u_pad     = u_al[2:0] - u_off[2:0];
  assign u_end     = u_al + {13'd0, size_q};
  assign u_fit     = {1'b0, h_len} >= ({14'd0, u_pad} + {13'd0, size_q});
  assign u_remain  = h_len - {13'd0, u_pad} - {12'd0, size_q};
  assign pad_nz    = (u_pad != 3'd0);
  assign remain_nz = (u_remain != 16'd0);
  assign len_gt    = (h_len > {12'd0, size_q});
  assign bpos      = {u_al[15:0], 3'b000};

  // Scan position against the hole count
  logic [CntW-1:0] idx_x;
  logic            last, dn_last, cnt_full;
  assign idx_x    = CntW'(idx_q);
  assign last     = ((idx_x + CntW'(1)) == cnt_q);
  assign dn_last  = ((idx_x + CntW'(2)) == cnt_q);
  assign cnt_full = (cnt_q >= CntMax);

  // End-of-record rounding to the pointer word
  logic [3:0]  wm1;
  logic [16:0] total;
  always_comb begin
    if (pwb_q[3]) begin
      wm1 = 4'd7;
    end else if (pwb_q[2]) begin
      wm1 = 4'd3;
    end else if (pwb_q[1]) begin
      wm1 = 4'd1;
    end else begin
      wm1 = 4'd0;
    end
    if (slot_q != 16'd0) begin
      total = ({1'b0, send_q} + {13'd0, wm1}) & ~{13'd0, wm1};
    end else begin
      total = {1'b0, send_q};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.cmd)
            CMD_SCALAR: begin
              if (in_data_i.field_bytes == 4'd0 && mid_byte) begin
                state_d = ST_EMIT;
              end else if (in_data_i.field_bytes == 4'd0 || size_ok) begin
                state_d = (cnt_q == '0) ? ST_APPEND : ST_SCAN;
              end
            end
            CMD_POINTER, CMD_END: state_d = ST_EMIT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (u_fit) begin
          if (pad_nz) begin
            state_d = (remain_nz && !cnt_full) ? ST_SHIFT_UP : ST_EMIT;
          end else if (len_gt || last) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SHIFT_DN;
          end
        end else if (last) begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: state_d = ST_EMIT;
      ST_SHIFT_UP: begin
        if (idx_q == ins_at_q) state_d = ST_EMIT;
      end
      ST_SHIFT_DN: begin
        if (dn_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and table updates
  always_comb begin
    cnt_d       = cnt_q;
    bit_cur_d   = bit_cur_q;
    send_d      = send_q;
    slot_d      = slot_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    size_d      = size_q;
    is_bool_d   = is_bool_q;
    idx_d       = idx_q;
    ins_at_d    = ins_at_q;
    ins_word_d  = ins_word_q;
    res_kind_d  = res_kind_q;
    res_pos_d   = res_pos_q;
    res_area_d  = res_area_q;
    res_slots_d = res_slots_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = rdata_q;

    // Drop the output beat once taken
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_pos_d   = '0;
          res_area_d  = '0;
          res_slots_d = '0;
          idx_d       = '0;
          case (in_data_i.cmd)
            CMD_SCALAR: begin
              is_bool_d = (in_data_i.field_bytes == 4'd0);
              size_d    = (in_data_i.field_bytes == 4'd0) ? 4'd1 : in_data_i.field_bytes;
              if (in_data_i.field_bytes == 4'd0 && mid_byte) begin
                res_kind_d = KIND_BIT;
                res_pos_d  = bit_cur_q;
                bit_cur_d  = bit_cur_q + PosW'(1);
              end
            end
            CMD_POINTER: begin
              res_kind_d = KIND_SLOT;
              res_pos_d  = {3'b000, slot_q};
              if (slot_q == 16'hFFFF) begin
                ovf_d = 1'b1;
              end else begin
                slot_d = slot_q + 16'd1;
              end
            end
            CMD_END: begin
              res_kind_d  = KIND_TOTALS;
              res_slots_d = slot_q;
              if (total[16]) begin
                ovf_d      = 1'b1;
                res_area_d = 16'hFFFF;
              end else begin
                res_area_d = total[15:0];
              end
            end
            default: res_kind_d = res_kind_q;
          endcase
        end
      end

      ST_SCAN: begin
        if (u_fit) begin
          if (is_bool_q) begin
            res_kind_d = KIND_BIT;
            res_pos_d  = bpos;
            bit_cur_d  = bpos + PosW'(1);
          end else begin
            res_kind_d = KIND_BYTE;
            res_pos_d  = PosW'(u_al);
          end
          if (pad_nz) begin
            // Keep the front gap, insert the tail remainder after it
            mem_we = 1'b1;
            mem_wd = {h_off, 13'd0, u_pad};
            if (remain_nz) begin
              if (cnt_full) begin
                ovf_d = 1'b1;
              end else begin
                ins_at_d   = idx_q + IdxW'(1);
                ins_word_d = {u_end[15:0], u_remain};
                idx_d      = cnt_q[IdxW-1:0];
              end
            end
          end else if (len_gt) begin
            // Take the front of the hole
            mem_we = 1'b1;
            mem_wd = {u_end[15:0], h_len - {12'd0, size_q}};
          end else if (last) begin
            cnt_d = cnt_q - CntW'(1);
          end
        end else if (!last) begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      ST_APPEND: begin
        if (is_bool_q) begin
          res_kind_d = KIND_BIT;
          res_pos_d  = {send_q, 3'b000};
          bit_cur_d  = {send_q, 3'b000} + PosW'(1);
          if (send_q == 16'hFFFF) begin
            ovf_d = 1'b1;
          end else begin
            send_d = send_q + 16'd1;
          end
        end else begin
          res_kind_d = KIND_BYTE;
          res_pos_d  = PosW'(u_al);
          if (pad_nz) begin
            if (cnt_full) begin
              ovf_d = 1'b1;
            end else begin
              mem_we = 1'b1;
              mem_wa = cnt_q[IdxW-1:0];
              mem_wd = {send_q, 13'd0, u_pad};
              cnt_d  = cnt_q + CntW'(1);
            end
          end
          if (u_end[16]) begin
            ovf_d  = 1'b1;
            send_d = 16'hFFFF;
          end else begin
            send_d = u_end[15:0];
          end
        end
      end

      ST_SHIFT_UP: begin
        mem_we = 1'b1;
        if (idx_q == ins_at_q) begin
          mem_wd = ins_word_q;
          cnt_d  = cnt_q + CntW'(1);
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end

      ST_SHIFT_DN: begin
        mem_we = 1'b1;
        if (dn_last) begin
          cnt_d = cnt_q - CntW'(1);
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_d.result_kind        = res_kind_q;
          out_d.position           = res_pos_q;
          out_d.scalar_area_bytes  = res_area_q;
          out_d.pointer_slot_count = res_slots_q;
          out_d.overflow           = ovf_q;
          if (res_kind_q == KIND_TOTALS) begin
            cnt_d     = '0;
            bit_cur_d = '0;
            send_d    = '0;
            slot_d    = '0;
            ovf_d     = 1'b0;
          end
        end
      end

      default: out_d = out_q;
    endcase

    // Read one entry ahead of the next step
    case (state_d)
      ST_SHIFT_UP: rd_addr = idx_d - IdxW'(1);
      ST_SHIFT_DN: rd_addr = idx_d + IdxW'(1);
      default:     rd_addr = idx_d;
    endcase
  end

  // Configuration port
  logic reg_sel;
  assign reg_sel = (paddr[AddrW-1:2] == RegPwbIdx);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DataW-4){1'b0}}, pwb_q} : '0;
  assign pwb_d   = (psel && penable && pwrite && reg_sel) ? pwdata[3:0] : pwb_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      bit_cur_q   <= '0;
      send_q      <= '0;
      slot_q      <= '0;
      ovf_q       <= 1'b0;
      pwb_q       <= PwbReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bit_cur_q   <= bit_cur_d;
      send_q      <= send_d;
      slot_q      <= slot_d;
      ovf_q       <= ovf_d;
      pwb_q       <= pwb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q      <= size_d;
    is_bool_q   <= is_bool_d;
    idx_q       <= idx_d;
    ins_at_q    <= ins_at_d;
    ins_word_q  <= ins_word_d;
    res_kind_q  <= res_kind_d;
    res_pos_q   <= res_pos_d;
    res_area_q  <= res_area_d;
    res_slots_q <= res_slots_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hole_mem[mem_wa] <= mem_wd;
    rdata_q <= hole_mem[rd_addr];
  end

  // Hole count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("hole count past table depth");

  // An insert shift only runs with a free entry
  a_shift_up_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT_UP) |-> (cnt_q < CntMax) && (CntW'(ins_at_q) <= cnt_q))
    else $error("insert without room in hole table");

  // A remove shift stays inside the live entries
  a_shift_dn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT_DN) |-> ((idx_x + CntW'(2)) <= cnt_q))
    else $error("remove shift past hole count");

  // Totals leave a cleared layout behind
  a_totals_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && res_kind_q == KIND_TOTALS)
    |=> (cnt_q == '0) && (slot_q == 16'd0) && (send_q == 16'd0) && !ovf_q)
    else $error("layout not cleared after totals");

  // A result beat is loaded only from the emit step
  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || !out_stall_i) && out_valid_d |-> (state_q == ST_EMIT))
    else $error("result beat loaded outside emit step");

endmodule

// ===== bench/sfla_tb_pkg.sv =====
// Scoreboard for the struct field layout allocator bench: layout predictor and result checks.
package sfla_tb_pkg;

  import sfla_pkg::*;

  localparam int unsigned HoleSlots = MaxHolesDefault;
  localparam int unsigned SizeCap   = 65535;

  class layout_scoreboard;

    int unsigned hole_off [HoleSlots];
    int unsigned hole_len [HoleSlots];
    int unsigned holes;
    int unsigned bit_pos;
    int unsigned scalar_end;
    int unsigned slots;
    bit          ovf;
    logic [3:0]  word_reg;
    sfla_out_t   expected_q [$];
    int unsigned errors;

    function new();
      word_reg = PwbReset;
      errors   = 0;
      clear_layout();
    endfunction

    function void clear_layout();
      holes      = 0;
      bit_pos    = 0;
      scalar_end = 0;
      slots      = 0;
      ovf        = 1'b0;
    endfunction

    function void set_word(logic [3:0] value);
      word_reg = value;
    endfunction

    function int unsigned align_up(int unsigned x, int unsigned a);
      return (x + a - 1) & ~(a - 1);
    endfunction

    // Insert at a table position; a full table drops the hole and flags overflow.
    function void add_hole(int unsigned at, int unsigned off, int unsigned len);
      int unsigned i;
      if (holes >= HoleSlots || at > holes) begin
        ovf = 1'b1;
        return;
      end
      for (i = holes; i > at; i--) begin
        hole_off[i] = hole_off[i-1];
        hole_len[i] = hole_len[i-1];
      end
      hole_off[at] = off & 16'hFFFF;
      hole_len[at] = len & 16'hFFFF;
      holes++;
    endfunction

    function void drop_hole(int unsigned at);
      int unsigned i;
      if (at >= holes) return;
      for (i = at; i + 1 < holes; i++) begin
        hole_off[i] = hole_off[i+1];
        hole_len[i] = hole_len[i+1];
      end
      holes--;
    endfunction

    // First fit; holes shorter than their alignment pad are skipped.
    function bit fit_hole(int unsigned nbytes, output int unsigned at);
      int unsigned i, off, len, al, pad, rest;
      for (i = 0; i < holes; i++) begin
        off = hole_off[i];
        len = hole_len[i];
        al  = align_up(off, nbytes);
        pad = al - off;
        if (len < pad || len - pad < nbytes) continue;
        if (pad != 0) begin
          rest        = len - pad - nbytes;
          hole_len[i] = pad;
          if (rest != 0) add_hole(i + 1, al + nbytes, rest);
        end else if (len > nbytes) begin
          hole_off[i] = off + nbytes;
          hole_len[i] = len - nbytes;
        end else begin
          drop_hole(i);
        end
        at = al;
        return 1'b1;
      end
      at = 0;
      return 1'b0;
    endfunction

    function int unsigned place_bit();
      int unsigned at, pos;
      if ((bit_pos & 7) == 0) begin
        if (fit_hole(1, at)) begin
          bit_pos = (at * 8) & 19'h7FFFF;
        end else begin
          bit_pos = (scalar_end * 8) & 19'h7FFFF;
          if (scalar_end >= SizeCap) ovf = 1'b1;
          else scalar_end++;
        end
      end
      pos     = bit_pos;
      bit_pos = (bit_pos + 1) & 19'h7FFFF;
      return pos;
    endfunction

    function int unsigned place_bytes(int unsigned nbytes);
      int unsigned at, al, stop;
      if (fit_hole(nbytes, at)) return at;
      al = align_up(scalar_end, nbytes);
      if (al != scalar_end) add_hole(holes, scalar_end, al - scalar_end);
      stop = al + nbytes;
      if (stop > SizeCap) begin
        ovf  = 1'b1;
        stop = SizeCap;
      end
      scalar_end = stop;
      return al;
    endfunction

    // Advance the predicted layout by one accepted beat and queue its result.
    function void note_input(sfla_in_t beat);
      sfla_out_t   exp;
      int unsigned pos, total, word;
      bit          emits;
      exp   = '0;
      pos   = 0;
      emits = 1'b1;
      case (beat.cmd)
        CMD_SCALAR: begin
          if (beat.field_bytes == 4'd0) begin
            exp.result_kind = KIND_BIT;
            pos = place_bit();
          end else if (beat.field_bytes == 4'd1 || beat.field_bytes == 4'd2 ||
                       beat.field_bytes == 4'd4 || beat.field_bytes == 4'd8) begin
            exp.result_kind = KIND_BYTE;
            pos = place_bytes(beat.field_bytes);
          end else begin
            emits = 1'b0;
          end
        end
        CMD_POINTER: begin
          exp.result_kind = KIND_SLOT;
          pos = slots;
          if (slots >= SizeCap) ovf = 1'b1;
          else slots++;
        end
        CMD_END: begin
          word  = word_reg[3] ? 8 : word_reg[2] ? 4 : word_reg[1] ? 2 : 1;
          total = scalar_end;
          if (slots > 0) total = align_up(total, word);
          if (total > SizeCap) begin
            ovf   = 1'b1;
            total = SizeCap;
          end
          exp.result_kind        = KIND_TOTALS;
          exp.scalar_area_bytes  = total[SizeW-1:0];
          exp.pointer_slot_count = slots[SizeW-1:0];
        end
        default: emits = 1'b0;
      endcase
      if (!emits) return;
      exp.position = pos[PosW-1:0];
      exp.overflow = ovf;
      expected_q.push_back(exp);
      if (beat.cmd == CMD_END) clear_layout();
    endfunction

    function bit field_differs(string name, longint unsigned e, longint unsigned g);
      if (e == g) return 1'b0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, g);
      return 1'b1;
    endfunction

    function void check_result(sfla_out_t got);
      sfla_out_t exp;
      bit        bad;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      bad = 1'b0;
      bad |= field_differs("result_kind", exp.result_kind, got.result_kind);
      bad |= field_differs("position", exp.position, got.position);
      bad |= field_differs("scalar_area_bytes", exp.scalar_area_bytes, got.scalar_area_bytes);
      bad |= field_differs("pointer_slot_count", exp.pointer_slot_count, got.pointer_slot_count);
      bad |= field_differs("overflow", exp.overflow, got.overflow);
      if (bad) errors++;
    endfunction

    function void report_leftover();
      if (expected_q.size() == 0) return;
      $display("%0t: results missing, expected %0d more, actual 0", $time, expected_q.size());
      errors++;
    endfunction

  endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for the struct field layout allocator: drivers, monitor and run control.
module tb_top;

  import sfla_pkg::*;
  import sfla_tb_pkg::*;

  // Command 3 is not a package code; the block takes it and drops it.
  localparam logic [1:0]       CmdUnknown  = 2'd3;
  localparam logic [AddrW-1:0] PwbAddr     = {RegPwbIdx, 2'b00};
  // Longest item: scan 16 holes, then append or shift the table entries, then emit. Round up well.
  localparam int unsigned      DrainCycles = 64;
  localparam int unsigned      RandomItems = 540;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  sfla_in_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  sfla_out_t        out_data_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  layout_scoreboard sb = new();

  int unsigned good_items;

  struct_field_layout_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10000000;
    $display("FAILURE");
    $finish;
  end

  // Check every result beat taken at an edge; sample pre-edge values only.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Receiver back-pressure: alternate free runs and stalls, mostly short,
  // now and then long.
  initial begin : out_stall_gen
    int unsigned hold_n;
    bit          level;
    out_stall_i <= 1'b0;
    hold_n = 0;
    level  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_n == 0) begin
        if (level) begin
          level  = 1'b0;
          hold_n = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 12);
        end else begin
          level  = 1'b1;
          hold_n = ($urandom_range(0, 99) < 10) ? $urandom_range(15, 50)
                                                : $urandom_range(1, 3);
        end
      end
      out_stall_i <= level;
      hold_n--;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one beat, hold it until taken, then note it and maybe idle.
  // Called right after a rising edge; valid is only lowered for a real gap.
  task automatic send(input logic [1:0] cmd, input logic [3:0] nbytes);
    sfla_in_t    beat;
    int unsigned gap;
    beat.cmd         = cmd;
    beat.field_bytes = nbytes;
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(beat);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid, drain every expected result, then let a dropped item finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, done at the edge with pready high.
  task automatic write_word(input logic [3:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PwbAddr;
    pwdata  <= {{(DataW-4){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_word(value);
    @(posedge clk_i);
  endtask

  task automatic send_noise();
    logic [3:0] nbytes;
    if ($urandom_range(0, 1)) begin
      send(CmdUnknown, 4'($urandom_range(0, 15)));
    end else begin
      do nbytes = 4'($urandom_range(0, 15));
      while (nbytes == 4'd0 || nbytes == 4'd1 || nbytes == 4'd2 ||
             nbytes == 4'd4 || nbytes == 4'd8);
      send(CMD_SCALAR, nbytes);
    end
  endtask

  task automatic send_field();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20)      send(CMD_POINTER, 4'($urandom_range(0, 15)));
    else if (r < 45) send(CMD_SCALAR, 4'd0);
    else if (r < 60) send(CMD_SCALAR, 4'd1);
    else if (r < 73) send(CMD_SCALAR, 4'd2);
    else if (r < 86) send(CMD_SCALAR, 4'd4);
    else             send(CMD_SCALAR, 4'd8);
  endtask

  // One random record: fields with a sprinkle of ignored beats, then its end.
  task automatic run_record();
    int unsigned fields, r, i;
    r = $urandom_range(0, 99);
    if (r < 70)      fields = $urandom_range(1, 12);
    else if (r < 95) fields = $urandom_range(13, 30);
    else             fields = $urandom_range(31, 60);
    for (i = 0; i < fields; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_noise();
      end else begin
        send_field();
        good_items++;
      end
    end
    send(CMD_END, 4'($urandom_range(0, 15)));
    good_items++;
  endtask

  initial begin : stimulus
    int unsigned n, r;
    good_items = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed record at the reset word size: bits, a gap hole split and
    // consumed, an exact-fit removal, an append gap, a pad-only split,
    // pointers and every kind of ignored beat.
    send(CMD_SCALAR, 4'd0);
    send(CMD_SCALAR, 4'd0);
    send(CMD_SCALAR, 4'd8);
    send(CMD_SCALAR, 4'd2);
    send(CMD_SCALAR, 4'd1);
    send(CMD_SCALAR, 4'd4);
    send(CMD_SCALAR, 4'd1);
    send(CMD_SCALAR, 4'd4);
    send(CMD_SCALAR, 4'd2);
    send(CMD_POINTER, 4'd0);
    send(CMD_POINTER, 4'd15);
    send(CmdUnknown, 4'd15);
    send(CMD_SCALAR, 4'd3);
    send(CMD_SCALAR, 4'd12);
    send(CMD_END, 4'd0);

    // Round to the widest word, then with word size 0 (acts as 1) and 15.
    write_word(4'd8);
    send(CMD_SCALAR, 4'd1);
    send(CMD_POINTER, 4'd0);
    send(CMD_END, 4'd0);
    write_word(4'd0);
    send(CMD_SCALAR, 4'd1);
    send(CMD_POINTER, 4'd0);
    send(CMD_END, 4'd0);
    write_word(4'd15);
    send(CMD_SCALAR, 4'd2);
    send(CMD_POINTER, 4'd0);
    send(CMD_END, 4'd0);

    // Random records; change the word size between some of them.
    write_word(4'd1);
    good_items = 0;
    while (good_items < RandomItems) begin
      if ($urandom_range(0, 99) < 25) begin
        r = $urandom_range(0, 99);
        if (r < 40) write_word(r[0] ? 4'd1 : 4'd8);
        else        write_word(4'($urandom_range(0, 15)));
      end
      run_record();
    end

    // Drain with a bound, then let the pipeline empty before judging.
    in_valid_i <= 1'b0;
    for (n = 0; n < 200000 && sb.expected_q.size() != 0; n++) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.report_leftover();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
